// ===== sv/cbc_pkg.sv =====
// Shared types and constants of the cartridge bank controller.
package cbc_pkg;

  localparam logic [2:0] CT_NONE  = 3'd0;
  localparam logic [2:0] CT_MBC1  = 3'd1;
  localparam logic [2:0] CT_MBC1M = 3'd2;
  localparam logic [2:0] CT_MBC2  = 3'd3;
  localparam logic [2:0] CT_MBC3  = 3'd4;
  localparam logic [2:0] CT_MBC5  = 3'd5;

  localparam logic [2:0] REG_CONTROLLER_TYPE = 3'd0;
  localparam logic [2:0] REG_RAM_FITTED      = 3'd1;
  localparam logic [2:0] REG_RUMBLE_FITTED   = 3'd2;
  localparam logic [2:0] REG_RAM_BANK_COUNT  = 3'd3;
  localparam logic [2:0] REG_ROM_BANK_COUNT  = 3'd4;
  localparam logic [2:0] REG_RAM_SIZE_BYTES  = 3'd5;

  localparam logic [1:0] WIN_ENABLE   = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK = 2'd1;
  localparam logic [1:0] WIN_RAM_BANK = 2'd2;
  localparam logic [1:0] WIN_MODE     = 2'd3;

  localparam logic [2:0] RAM_WINDOW = 3'b101;
  localparam logic [3:0] ENABLE_KEY = 4'hA;
  localparam logic [9:0] ROM_HIGH_BYTE_MIN = 10'd256;

  localparam int unsigned PADDR_W = 5;

  typedef struct packed {
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } cbc_in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] rom_bank;
    logic [3:0]  ram_bank;
    logic        ram_on;
  } cbc_out_t;

  typedef struct packed {
    logic [2:0]  controller_type;
    logic        ram_fitted;
    logic        rumble_fitted;
    logic [4:0]  ram_bank_count;
    logic [9:0]  rom_bank_count;
    logic [17:0] ram_size_bytes;
  } cbc_cfg_t;

  typedef struct packed {
    logic [15:0] rom_bank;
    logic [3:0]  ram_bank;
    logic [1:0]  high_bits;
    logic        banking_mode;
    logic        ram_en;
  } cbc_bank_t;

endpackage

// ===== sv/cartridge_bank_controller_core.sv =====
// Top level of the cartridge bank controller: register port, external RAM and result stage.
// One bus access is taken per cycle when the result stage can advance and no sweep runs; its
// result beat appears in the cycle after acceptance from the registered read port of the
// single-port byte-wide external RAM, which holds RAM_BYTES bytes. Control writes update the
// bank registers at the accepting edge. After reset the RAM is swept to zero one byte per
// cycle; no beat is taken until the sweep ends; register writes and reads are served throughout.
module cartridge_bank_controller_core #(
  parameter int unsigned RAM_BYTES = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cbc_pkg::cbc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cbc_pkg::cbc_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(RAM_BYTES - 1);
  localparam logic [17:0]   RamLimit = 18'(RAM_BYTES);

  cbc_pkg::cbc_cfg_t  cfg_q;
  cbc_pkg::cbc_bank_t bank_q;

  logic          in_fire, ctrl_wr, in_window, type_ok, clock_sel, in_range, ram_ok;
  logic          ram_we, ram_re;
  logic [3:0]    bank_sel, bank_mask;
  logic [16:0]   ram_addr;
  logic [AW-1:0] ram_idx;
  logic [7:0]    ram_wdata;
  logic [2:0]    reg_idx;

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          out_valid_q, rd_hit_q, rd_nib_q;
  logic [7:0]    rdata_q;
  logic [7:0]    mem [RAM_BYTES];

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.controller_type <= cbc_pkg::CT_NONE;
      cfg_q.ram_fitted      <= 1'b0;
      cfg_q.rumble_fitted   <= 1'b0;
      cfg_q.ram_bank_count  <= 5'd1;
      cfg_q.rom_bank_count  <= 10'd2;
      cfg_q.ram_size_bytes  <= 18'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        cbc_pkg::REG_CONTROLLER_TYPE: cfg_q.controller_type <= pwdata[2:0];
        cbc_pkg::REG_RAM_FITTED:      cfg_q.ram_fitted      <= pwdata[0];
        cbc_pkg::REG_RUMBLE_FITTED:   cfg_q.rumble_fitted   <= pwdata[0];
        cbc_pkg::REG_RAM_BANK_COUNT:  cfg_q.ram_bank_count  <= pwdata[4:0];
        cbc_pkg::REG_ROM_BANK_COUNT:  cfg_q.rom_bank_count  <= pwdata[9:0];
        cbc_pkg::REG_RAM_SIZE_BYTES:  cfg_q.ram_size_bytes  <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cbc_pkg::REG_CONTROLLER_TYPE: prdata = {29'd0, cfg_q.controller_type};
      cbc_pkg::REG_RAM_FITTED:      prdata = {31'd0, cfg_q.ram_fitted};
      cbc_pkg::REG_RUMBLE_FITTED:   prdata = {31'd0, cfg_q.rumble_fitted};
      cbc_pkg::REG_RAM_BANK_COUNT:  prdata = {27'd0, cfg_q.ram_bank_count};
      cbc_pkg::REG_ROM_BANK_COUNT:  prdata = {22'd0, cfg_q.rom_bank_count};
      cbc_pkg::REG_RAM_SIZE_BYTES:  prdata = {14'd0, cfg_q.ram_size_bytes};
      default:                      prdata = 32'd0;
    endcase
  end

  // Access decode.
  assign in_ready_o = !clr_busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ctrl_wr    = in_fire && in_data_i.mode && !in_data_i.bus_address[15];
  assign in_window  = (in_data_i.bus_address[15:13] == cbc_pkg::RAM_WINDOW);

  cbc_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (ctrl_wr),
    .addr_i (in_data_i.bus_address),
    .data_i (in_data_i.write_byte),
    .cfg_i  (cfg_q),
    .bank_o (bank_q)
  );

  always_comb begin
    bank_mask = 4'(cfg_q.ram_bank_count - 5'd1);
    bank_sel  = bank_q.ram_bank;
    if (cfg_q.controller_type == cbc_pkg::CT_MBC5 && cfg_q.rumble_fitted) begin
      bank_sel[3] = 1'b0;
    end
    bank_sel = bank_sel & bank_mask;
  end

  assign ram_addr  = {bank_sel, in_data_i.bus_address[12:0]};
  assign ram_idx   = ram_addr[AW-1:0];
  assign in_range  = ({1'b0, ram_addr} < cfg_q.ram_size_bytes) && ({1'b0, ram_addr} < RamLimit);
  assign type_ok   = cfg_q.controller_type inside {[cbc_pkg::CT_MBC1:cbc_pkg::CT_MBC5]};
  assign clock_sel = (cfg_q.controller_type == cbc_pkg::CT_MBC3) && bank_q.ram_bank[3];
  assign ram_ok    = in_window && bank_q.ram_en && type_ok && !clock_sel && in_range;
  assign ram_we    = in_fire && in_data_i.mode && ram_ok;
  assign ram_re    = in_fire && !in_data_i.mode && ram_ok;
  assign ram_wdata = (cfg_q.controller_type == cbc_pkg::CT_MBC2) ?
                     {4'h0, in_data_i.write_byte[3:0]} : in_data_i.write_byte;

  // External RAM with the clearing sweep after reset.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'd0;
    end else if (ram_we) begin
      mem[ram_idx] <= ram_wdata;
    end
    if (ram_re) begin
      rdata_q <= mem[ram_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_hit_q    <= 1'b0;
      rd_nib_q    <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
      rd_hit_q    <= ram_re;
      rd_nib_q    <= (cfg_q.controller_type == cbc_pkg::CT_MBC2);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.read_byte = !rd_hit_q ? 8'hFF :
                                rd_nib_q  ? {4'hF, rdata_q[3:0]} : rdata_q;
  assign out_data_o.rom_bank  = bank_q.rom_bank;
  assign out_data_o.ram_bank  = bank_q.ram_bank;
  assign out_data_o.ram_on    = bank_q.ram_en;

  a_no_beat_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("Beat accepted during the RAM clearing sweep.");

  a_bank_hold_on_ram_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !ctrl_wr) |=> (bank_q == $past(bank_q)))
    else $error("Bank registers changed on an access that is not a control write.");

  a_read_data_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(rdata_q))
    else $error("RAM read data changed while the result beat was stalled.");

endmodule

// ===== sv/cbc_bank.sv =====
// Bank and enable registers with the controller-specific write decode.
module cbc_bank (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [15:0]       addr_i,
  input  logic [7:0]        data_i,
  input  cbc_pkg::cbc_cfg_t cfg_i,
  output cbc_pkg::cbc_bank_t bank_o
);

  cbc_pkg::cbc_bank_t bank_d, bank_q;
  logic [15:0] rb;
  logic [1:0]  win;
  logic        en_val;

  assign win    = addr_i[14:13];
  assign en_val = cfg_i.ram_fitted && (data_i[3:0] == cbc_pkg::ENABLE_KEY);

  always_comb begin
    bank_d = bank_q;
    rb     = bank_q.rom_bank;
    if (wr_i) begin
      case (cfg_i.controller_type)
        cbc_pkg::CT_MBC1, cbc_pkg::CT_MBC1M: begin
          case (win)
            cbc_pkg::WIN_ENABLE: begin
              bank_d.ram_en = en_val;
            end
            cbc_pkg::WIN_ROM_BANK: begin
              if (cfg_i.controller_type == cbc_pkg::CT_MBC1) begin
                rb = {9'd0, bank_q.rom_bank[6:5], data_i[4:0]};
              end else begin
                rb = {10'd0, bank_q.rom_bank[5:4], data_i[3:0]};
              end
              if (data_i[4:0] == 5'd0) begin
                rb = rb + 16'd1;
              end
            end
            cbc_pkg::WIN_RAM_BANK: begin
              bank_d.high_bits = data_i[1:0];
              if (bank_q.banking_mode) begin
                bank_d.ram_bank = {2'b00, data_i[1:0]};
              end
              if (cfg_i.controller_type == cbc_pkg::CT_MBC1) begin
                rb = {9'd0, data_i[1:0], bank_q.rom_bank[4:0]};
              end else begin
                rb = {10'd0, data_i[1:0], bank_q.rom_bank[3:0]};
              end
            end
            default: begin
              bank_d.banking_mode = data_i[0];
              bank_d.ram_bank     = data_i[0] ? {2'b00, bank_q.high_bits} : 4'd0;
            end
          endcase
        end
        cbc_pkg::CT_MBC2: begin
          case (win)
            cbc_pkg::WIN_ENABLE: begin
              if (!addr_i[8]) begin
                bank_d.ram_en = en_val;
              end
            end
            cbc_pkg::WIN_ROM_BANK: begin
              if (addr_i[8]) begin
                rb = (data_i[3:0] == 4'd0) ? 16'd1 : {12'd0, data_i[3:0]};
              end
            end
            default: begin
            end
          endcase
        end
        cbc_pkg::CT_MBC3: begin
          case (win)
            cbc_pkg::WIN_ENABLE: begin
              bank_d.ram_en = en_val;
            end
            cbc_pkg::WIN_ROM_BANK: begin
              rb = (data_i[6:0] == 7'd0) ? 16'd1 : {9'd0, data_i[6:0]};
            end
            cbc_pkg::WIN_RAM_BANK: begin
              bank_d.ram_bank = data_i[3:0];
            end
            default: begin
            end
          endcase
        end
        cbc_pkg::CT_MBC5: begin
          case (win)
            cbc_pkg::WIN_ENABLE: begin
              bank_d.ram_en = en_val;
            end
            cbc_pkg::WIN_ROM_BANK: begin
              if (!addr_i[12]) begin
                rb = {bank_q.rom_bank[15:8], data_i};
              end else if (cfg_i.rom_bank_count > cbc_pkg::ROM_HIGH_BYTE_MIN) begin
                rb = {data_i, bank_q.rom_bank[7:0]};
              end
            end
            cbc_pkg::WIN_RAM_BANK: begin
              bank_d.ram_bank = data_i[3:0];
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    bank_d.rom_bank = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q.rom_bank     <= 16'd1;
      bank_q.ram_bank     <= 4'd0;
      bank_q.high_bits    <= 2'd0;
      bank_q.banking_mode <= 1'b0;
      bank_q.ram_en       <= 1'b0;
    end else begin
      bank_q <= bank_d;
    end
  end

  assign bank_o = bank_q;

endmodule
